// ===== rtl/core/tlsg_pkg.sv =====
package tlsg_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned GRAD_WIDTH      = 32;
  localparam int unsigned NODES           = 4;
  localparam int unsigned AXES            = 3;
  localparam int unsigned EDGES           = 3;
  localparam int unsigned AXW             = 2;
  localparam int unsigned FIFO_DEPTH      = 2;

  localparam logic [GRAD_WIDTH-1:0] GRAD_MAX = {1'b0, {(GRAD_WIDTH - 1){1'b1}}};
  localparam logic [GRAD_WIDTH-1:0] GRAD_MIN = {1'b1, {(GRAD_WIDTH - 1){1'b0}}};

  localparam logic [AXW-1:0] LAST_NODE = AXW'(NODES - 1);

  typedef logic [AXW-1:0] axis_t;

  function automatic axis_t next_axis(axis_t k);
    axis_t r;
    r = (k == axis_t'(AXES - 1)) ? axis_t'(0) : k + axis_t'(1);
    return r;
  endfunction

endpackage

// ===== rtl/core/tet_linear_shape_gradient_core.sv =====
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_ready_o  | v0_x_i .. v3_z_i, one tetrahedron
// out     | output    | out_valid_o / out_ready_i| node_index_o, grad_*_o, degenerate_o, last_o
//
// Each item gives four result items, vertex 0 first, last_o on vertex 3.
// The back end works on one item at a time, in two phases:
// seven rounds of bit-serial multiply lanes, then four rounds of the 33-step dividers.
// The front register and a two-entry queue take new items while the back end works.
// Reset is asynchronous, active low; it clears all handshake and sequencing state.
// A stalled output holds its result; the back end waits, the queue keeps filling.
module tet_linear_shape_gradient_core #(
  parameter int unsigned COORD_WIDTH = tlsg_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = tlsg_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]          v0_x_i,
  input  logic signed [COORD_WIDTH-1:0]          v0_y_i,
  input  logic signed [COORD_WIDTH-1:0]          v0_z_i,
  input  logic signed [COORD_WIDTH-1:0]          v1_x_i,
  input  logic signed [COORD_WIDTH-1:0]          v1_y_i,
  input  logic signed [COORD_WIDTH-1:0]          v1_z_i,
  input  logic signed [COORD_WIDTH-1:0]          v2_x_i,
  input  logic signed [COORD_WIDTH-1:0]          v2_y_i,
  input  logic signed [COORD_WIDTH-1:0]          v2_z_i,
  input  logic signed [COORD_WIDTH-1:0]          v3_x_i,
  input  logic signed [COORD_WIDTH-1:0]          v3_y_i,
  input  logic signed [COORD_WIDTH-1:0]          v3_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [tlsg_pkg::AXW-1:0]               node_index_o,
  output logic signed [tlsg_pkg::GRAD_WIDTH-1:0] grad_x_o,
  output logic signed [tlsg_pkg::GRAD_WIDTH-1:0] grad_y_o,
  output logic signed [tlsg_pkg::GRAD_WIDTH-1:0] grad_z_o,
  output logic                                   degenerate_o,
  output logic                                   last_o
);
  import tlsg_pkg::*;

  localparam int unsigned EW = EDGES * AXES * (COORD_WIDTH + 1);

  logic [NODES-1:0][AXES-1:0][COORD_WIDTH-1:0]  vtx;
  logic [EDGES-1:0][AXES-1:0][COORD_WIDTH:0]    fr_edge, bk_edge;
  logic                                         fr_valid, fr_ready;
  logic                                         bk_valid, bk_ready;
  logic [EW-1:0]                                q_data;

  assign vtx[0] = {v0_z_i, v0_y_i, v0_x_i};
  assign vtx[1] = {v1_z_i, v1_y_i, v1_x_i};
  assign vtx[2] = {v2_z_i, v2_y_i, v2_x_i};
  assign vtx[3] = {v3_z_i, v3_y_i, v3_x_i};

  tlsg_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .vtx_i        (vtx),
    .edge_valid_o (fr_valid),
    .edge_ready_i (fr_ready),
    .edge_o       (fr_edge)
  );

  tlsg_fifo #(
    .WIDTH (EW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_edge),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (q_data)
  );

  assign bk_edge = q_data;

  tlsg_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .edge_valid_i (bk_valid),
    .edge_ready_o (bk_ready),
    .edge_i       (bk_edge),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .node_index_o (node_index_o),
    .grad_x_o     (grad_x_o),
    .grad_y_o     (grad_y_o),
    .grad_z_o     (grad_z_o),
    .degenerate_o (degenerate_o),
    .last_o       (last_o)
  );

endmodule

// ===== rtl/core/tlsg_front.sv =====
module tlsg_front #(
  parameter int unsigned COORD_WIDTH = tlsg_pkg::COORD_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [tlsg_pkg::NODES-1:0][tlsg_pkg::AXES-1:0][COORD_WIDTH-1:0] vtx_i,
  output logic edge_valid_o,
  input  logic edge_ready_i,
  output logic [tlsg_pkg::EDGES-1:0][tlsg_pkg::AXES-1:0][COORD_WIDTH:0] edge_o
);
  import tlsg_pkg::*;

  logic vld_q;
  logic [EDGES-1:0][AXES-1:0][COORD_WIDTH:0] edge_d, edge_q;

  assign in_ready_o   = !vld_q || edge_ready_i;
  assign edge_valid_o = vld_q;
  assign edge_o       = edge_q;

  // edges relative to vertex 0, one bit wider than the coordinates
  always_comb begin
    for (int v = 0; v < EDGES; v++) begin
      for (int k = 0; k < AXES; k++) begin
        edge_d[v][k] = $signed({vtx_i[v+1][k][COORD_WIDTH-1], vtx_i[v+1][k]})
                     - $signed({vtx_i[0][k][COORD_WIDTH-1], vtx_i[0][k]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      edge_q <= edge_d;
    end
  end

endmodule

// ===== rtl/core/tlsg_fifo.sv =====
module tlsg_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import tlsg_pkg::*;

  localparam int unsigned PTRW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [FIFO_DEPTH];
  logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNTW'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTRW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTRW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTRW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTRW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/tlsg_div.sv =====
module tlsg_div #(
  parameter int unsigned NUM_WIDTH = 69,
  parameter int unsigned DEN_WIDTH = 102,
  parameter int unsigned FRAC_BITS = tlsg_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [NUM_WIDTH-1:0]            num_i,
  input  logic        [DEN_WIDTH-1:0]            absd_i,
  input  logic                                   dneg_i,
  output logic                                   done_o,
  output logic signed [tlsg_pkg::GRAD_WIDTH-1:0] quo_o
);
  import tlsg_pkg::*;

  localparam int unsigned QB   = GRAD_WIDTH + 1;
  localparam int unsigned SHW  = NUM_WIDTH + 2 * FRAC_BITS + 1;
  localparam int unsigned AW   = ((SHW > DEN_WIDTH) ? SHW : DEN_WIDTH) + 1;
  localparam int unsigned BW   = DEN_WIDTH + 1;
  localparam int unsigned CNTW = $clog2(QB);

  localparam logic [1:0] D_IDLE  = 2'd0;
  localparam logic [1:0] D_CHECK = 2'd1;
  localparam logic [1:0] D_ITER  = 2'd2;
  localparam logic [1:0] D_DONE  = 2'd3;

  logic [1:0]            state_q;
  logic                  done_q;
  logic [AW-1:0]         a_q;
  logic [BW-1:0]         b_q, r_q;
  logic [QB-1:0]         lo_q, q_q;
  logic [CNTW-1:0]       cnt_q;
  logic                  neg_q, big_q;
  logic [GRAD_WIDTH-1:0] quo_q;
  logic [NUM_WIDTH-1:0]  an;
  logic [BW:0]           t, tdiff;
  logic                  qbit;
  logic [GRAD_WIDTH-1:0] sat;

  assign done_o = done_q;
  assign quo_o  = $signed(quo_q);

  assign an    = num_i[NUM_WIDTH-1] ? NUM_WIDTH'(-num_i) : NUM_WIDTH'(num_i);
  assign t     = {r_q, lo_q[QB-1]};
  assign tdiff = t - {1'b0, b_q};
  assign qbit  = t >= {1'b0, b_q};

  // round half away from zero was folded into the dividend; saturate here
  always_comb begin
    if (neg_q) begin
      if (big_q || q_q > {1'b0, GRAD_MIN}) begin
        sat = GRAD_MIN;
      end else begin
        sat = GRAD_WIDTH'(-q_q);
      end
    end else begin
      if (big_q || q_q > {1'b0, GRAD_MAX}) begin
        sat = GRAD_MAX;
      end else begin
        sat = q_q[GRAD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            state_q <= D_CHECK;
          end
        end
        D_CHECK: state_q <= D_ITER;
        D_ITER: begin
          if (cnt_q == '0) begin
            state_q <= D_DONE;
          end
        end
        D_DONE: begin
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          a_q   <= (AW'(an) << (2 * FRAC_BITS + 1)) + AW'(absd_i);
          b_q   <= {absd_i, 1'b0};
          neg_q <= num_i[NUM_WIDTH-1] ^ dneg_i;
        end
      end
      D_CHECK: begin
        big_q <= a_q[AW-1:QB] >= b_q;
        r_q   <= BW'(a_q[AW-1:QB]);
        lo_q  <= a_q[QB-1:0];
        q_q   <= '0;
        cnt_q <= CNTW'(QB - 1);
      end
      D_ITER: begin
        r_q   <= qbit ? BW'(tdiff) : BW'(t);
        lo_q  <= lo_q << 1;
        q_q   <= {q_q[QB-2:0], qbit};
        cnt_q <= cnt_q - CNTW'(1);
      end
      D_DONE: quo_q <= sat;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/tlsg_back.sv =====
module tlsg_back #(
  parameter int unsigned COORD_WIDTH = tlsg_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = tlsg_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   edge_valid_i,
  output logic                                   edge_ready_o,
  input  logic [tlsg_pkg::EDGES-1:0][tlsg_pkg::AXES-1:0][COORD_WIDTH:0] edge_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [tlsg_pkg::AXW-1:0]               node_index_o,
  output logic signed [tlsg_pkg::GRAD_WIDTH-1:0] grad_x_o,
  output logic signed [tlsg_pkg::GRAD_WIDTH-1:0] grad_y_o,
  output logic signed [tlsg_pkg::GRAD_WIDTH-1:0] grad_z_o,
  output logic                                   degenerate_o,
  output logic                                   last_o
);
  import tlsg_pkg::*;

  localparam int unsigned E    = COORD_WIDTH + 1;
  localparam int unsigned CW2  = 2 * E;
  localparam int unsigned CWC  = CW2 + 1;
  localparam int unsigned MW   = CWC;
  localparam int unsigned PW   = MW + E;
  localparam int unsigned NW   = CW2 + 3;
  localparam int unsigned DW   = 3 * E + 3;
  localparam int unsigned CNTW = $clog2(E);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_ACC    = 3'd2;
  localparam logic [2:0] S_PREP   = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  localparam logic [2:0] RND_DET = 3'd6;

  logic [2:0]             state_q;
  logic [2:0]             rnd_q;
  logic [CNTW-1:0]        cnt_q;
  logic [AXW-1:0]         node_q;
  logic signed [E-1:0]    e_q   [EDGES][AXES];
  logic signed [CWC-1:0]  c_q   [EDGES][AXES];
  logic signed [NW-1:0]   c0_q  [AXES];
  logic signed [CW2-1:0]  tmp_q [AXES];
  logic signed [PW-1:0]   acc_q [AXES];
  logic signed [PW-1:0]   acc_d [AXES];
  logic signed [PW-1:0]   term  [AXES];
  logic signed [MW-1:0]   mcand [AXES];
  logic        [E-1:0]    mplier[AXES];
  logic signed [DW-1:0]   det_q;
  logic        [DW-1:0]   absd_q;
  logic                   dneg_q, degen_q;
  logic [AXW-1:0]         ae, be;
  logic signed [NW-1:0]   num_d [AXES];
  logic                   div_start;
  logic [AXES-1:0]        div_done;
  logic signed [GRAD_WIDTH-1:0] quo [AXES];

  logic                   out_vld_q, out_deg_q, out_last_q;
  logic [AXW-1:0]         out_node_q;
  logic signed [GRAD_WIDTH-1:0] out_gx_q, out_gy_q, out_gz_q;
  logic                   emit_fire;

  assign edge_ready_o = state_q == S_IDLE;
  assign div_start    = state_q == S_DSTART;
  assign emit_fire    = (state_q == S_EMIT) && (!out_vld_q || out_ready_i);

  assign out_valid_o  = out_vld_q;
  assign node_index_o = out_node_q;
  assign grad_x_o     = out_gx_q;
  assign grad_y_o     = out_gy_q;
  assign grad_z_o     = out_gz_q;
  assign degenerate_o = out_deg_q;
  assign last_o       = out_last_q;

  // rounds 0..5: two products per cross product, round 6: determinant
  always_comb begin
    case (rnd_q[2:1])
      2'd0: begin
        ae = 2'd1;
        be = 2'd2;
      end
      2'd1: begin
        ae = 2'd2;
        be = 2'd0;
      end
      2'd2: begin
        ae = 2'd0;
        be = 2'd1;
      end
      default: begin
        ae = 2'd0;
        be = 2'd0;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      if (rnd_q == RND_DET) begin
        mcand[k]  = c_q[0][k];
        mplier[k] = e_q[0][k];
      end else if (rnd_q[0]) begin
        mcand[k]  = MW'(e_q[ae][next_axis(next_axis(AXW'(k)))]);
        mplier[k] = e_q[be][next_axis(AXW'(k))];
      end else begin
        mcand[k]  = MW'(e_q[ae][next_axis(AXW'(k))]);
        mplier[k] = e_q[be][next_axis(next_axis(AXW'(k)))];
      end
      term[k]  = mplier[k][cnt_q] ? PW'(mcand[k]) : '0;
      acc_d[k] = (cnt_q == CNTW'(E - 1)) ? -term[k] : (acc_q[k] <<< 1) + term[k];
      num_d[k] = (node_q == '0) ? c0_q[k] : NW'(c_q[node_q - 2'd1][k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rnd_q   <= '0;
      cnt_q   <= '0;
      node_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (edge_valid_i) begin
            rnd_q   <= '0;
            cnt_q   <= CNTW'(E - 1);
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          cnt_q <= cnt_q - CNTW'(1);
          if (cnt_q == '0) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (rnd_q == RND_DET) begin
            state_q <= S_PREP;
          end else begin
            rnd_q   <= rnd_q + 3'd1;
            cnt_q   <= CNTW'(E - 1);
            state_q <= S_MUL;
          end
        end
        S_PREP: begin
          node_q  <= '0;
          state_q <= S_DSTART;
        end
        S_DSTART: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_done[0]) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            node_q  <= node_q + 2'd1;
            state_q <= (node_q == LAST_NODE) ? S_IDLE : S_DSTART;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && edge_valid_i) begin
      for (int v = 0; v < EDGES; v++) begin
        for (int k = 0; k < AXES; k++) begin
          e_q[v][k] <= $signed(edge_i[v][k]);
        end
      end
    end
    if (state_q == S_MUL) begin
      for (int k = 0; k < AXES; k++) begin
        acc_q[k] <= acc_d[k];
      end
    end
    if (state_q == S_ACC) begin
      if (rnd_q == RND_DET) begin
        det_q <= DW'(acc_q[0]) + DW'(acc_q[1]) + DW'(acc_q[2]);
      end else begin
        for (int k = 0; k < AXES; k++) begin
          if (!rnd_q[0]) begin
            tmp_q[k] <= $signed(acc_q[k][CW2-1:0]);
          end else begin
            c_q[rnd_q[2:1]][k] <= CWC'(tmp_q[k]) - CWC'($signed(acc_q[k][CW2-1:0]));
          end
        end
      end
    end
    if (state_q == S_PREP) begin
      for (int k = 0; k < AXES; k++) begin
        c0_q[k] <= -(NW'(c_q[0][k]) + NW'(c_q[1][k]) + NW'(c_q[2][k]));
      end
      absd_q  <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      dneg_q  <= det_q[DW-1];
      degen_q <= det_q == '0;
    end
  end

  for (genvar k = 0; k < AXES; k++) begin : g_div
    tlsg_div #(
      .NUM_WIDTH (NW),
      .DEN_WIDTH (DW),
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   (num_d[k]),
      .absd_i  (absd_q),
      .dneg_i  (dneg_q),
      .done_o  (div_done[k]),
      .quo_o   (quo[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_node_q <= node_q;
      out_last_q <= node_q == LAST_NODE;
      out_deg_q  <= degen_q;
      out_gx_q   <= degen_q ? '0 : quo[0];
      out_gy_q   <= degen_q ? '0 : quo[1];
      out_gz_q   <= degen_q ? '0 : quo[2];
    end
  end

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_last_q == (out_node_q == LAST_NODE)))
    else $error("last flag does not match node index");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_deg_q) |-> (out_gx_q == '0 && out_gy_q == '0 && out_gz_q == '0))
    else $error("degenerate item with nonzero gradient");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done[0] == div_done[1]) && (div_done[0] == div_done[2]))
    else $error("divider lanes out of step");

  a_div_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DWAIT && div_done[0]) |=> (state_q == S_EMIT))
    else $error("quotient not taken to output");

endmodule

// ===== tb/tet_linear_shape_gradient_core_test.sv =====
`timescale 1ns / 100ps

module tet_linear_shape_gradient_core_test;

  localparam int unsigned CW = tlsg_pkg::COORD_WIDTH_DEF;
  localparam int unsigned FB = tlsg_pkg::FRAC_BITS_DEF;
  localparam int unsigned GW = tlsg_pkg::GRAD_WIDTH;
  localparam int unsigned NDIR = 16;
  localparam int unsigned NRND = 150;
  localparam longint CYCLE_LIMIT = 64'd2_000_000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [GW-1:0] grad_t;
  typedef logic signed [255:0] wide_t;

  typedef struct {
    coord_t c[12];
  } tet_t;

  typedef struct {
    logic [tlsg_pkg::AXW-1:0] node;
    grad_t gx;
    grad_t gy;
    grad_t gz;
    logic degen;
    logic last;
  } shape_grad_t;

  typedef struct {
    tet_t tet;
    logic typed;
    logic degen;
    grad_t g[12];
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t vin[12];
  logic out_valid;
  logic out_ready = 1'b0;
  logic [tlsg_pkg::AXW-1:0] node_index;
  grad_t grad_x, grad_y, grad_z;
  logic degenerate, last;

  shape_grad_t pending_grads[$];
  int errors = 0;
  longint cycles = 0;
  dir_row_t dir_rows[NDIR];

  always #5 clk = ~clk;

  tet_linear_shape_gradient_core DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .v0_x_i(vin[0]), .v0_y_i(vin[1]), .v0_z_i(vin[2]),
    .v1_x_i(vin[3]), .v1_y_i(vin[4]), .v1_z_i(vin[5]),
    .v2_x_i(vin[6]), .v2_y_i(vin[7]), .v2_z_i(vin[8]),
    .v3_x_i(vin[9]), .v3_y_i(vin[10]), .v3_z_i(vin[11]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .node_index_o(node_index),
    .grad_x_o(grad_x), .grad_y_o(grad_y), .grad_z_o(grad_z),
    .degenerate_o(degenerate), .last_o(last)
  );

  // round(num * 2^(2F) / den), ties away from zero, saturated
  function automatic grad_t scaled_quotient(wide_t num, wide_t den);
    logic neg;
    wide_t an, ad, q;
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = ((an <<< (2 * FB + 1)) + ad) / (ad <<< 1);
    if (neg) begin
      if (q > 256'sh80000000) return grad_t'(32'h80000000);
      return grad_t'(-q);
    end
    if (q > 256'sh7FFFFFFF) return grad_t'(32'h7FFFFFFF);
    return grad_t'(q);
  endfunction

  function automatic void tet_gradients(input tet_t t, output shape_grad_t r[4]);
    wide_t p[4][3], e[3][3], n[4][3], det;
    for (int v = 0; v < 4; v++)
      for (int k = 0; k < 3; k++) p[v][k] = wide_t'(t.c[v * 3 + k]);
    for (int v = 0; v < 3; v++)
      for (int k = 0; k < 3; k++) e[v][k] = p[v + 1][k] - p[0][k];
    for (int k = 0; k < 3; k++) begin
      int a, b;
      a = (k + 1) % 3;
      b = (k + 2) % 3;
      n[1][k] = e[1][a] * e[2][b] - e[1][b] * e[2][a];
      n[2][k] = e[2][a] * e[0][b] - e[2][b] * e[0][a];
      n[3][k] = e[0][a] * e[1][b] - e[0][b] * e[1][a];
    end
    for (int k = 0; k < 3; k++) n[0][k] = -(n[1][k] + n[2][k] + n[3][k]);
    det = e[0][0] * n[1][0] + e[0][1] * n[1][1] + e[0][2] * n[1][2];
    for (int v = 0; v < 4; v++) begin
      r[v].node = v[1:0];
      r[v].degen = (det == 0);
      r[v].last = (v == 3);
      r[v].gx = (det == 0) ? '0 : scaled_quotient(n[v][0], det);
      r[v].gy = (det == 0) ? '0 : scaled_quotient(n[v][1], det);
      r[v].gz = (det == 0) ? '0 : scaled_quotient(n[v][2], det);
    end
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 8) << FB) - coord_t'(4 << FB);
      2: return coord_t'($urandom_range(0, 2047)) - coord_t'(1024);
      default: return coord_t'($urandom_range(0, 65535) << 8) - coord_t'(1 << 23);
    endcase
  endfunction

  function automatic tet_t rand_tet();
    tet_t t;
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 12; i++) t.c[i] = rand_coord(mode);
    if ($urandom_range(0, 9) == 0) begin
      // coplanar: vertex 3 on the plane through 0, 1, 2
      for (int k = 0; k < 3; k++)
        t.c[9 + k] = t.c[3 + k] + t.c[6 + k] - t.c[k];
    end else if ($urandom_range(0, 19) == 0) begin
      for (int k = 0; k < 3; k++) t.c[6 + k] = t.c[k];
    end
    return t;
  endfunction

  function automatic tet_t unit_tet(coord_t s, coord_t o);
    tet_t t;
    for (int i = 0; i < 12; i++) t.c[i] = o;
    t.c[3] = o + s;
    t.c[7] = o + s;
    t.c[11] = o + s;
    return t;
  endfunction

  task automatic build_dir_rows();
    coord_t one;
    grad_t p1, m1;
    one = coord_t'(1 << FB);
    p1 = grad_t'(1 << FB);
    m1 = -p1;
    for (int r = 0; r < NDIR; r++) begin
      dir_rows[r].typed = 1'b0;
      dir_rows[r].degen = 1'b0;
      for (int i = 0; i < 12; i++) dir_rows[r].g[i] = '0;
      for (int i = 0; i < 12; i++) dir_rows[r].tet.c[i] = '0;
    end
    // reference element: gradients -1/-1/-1 then unit axes
    dir_rows[0].tet = unit_tet(one, '0);
    dir_rows[0].typed = 1'b1;
    dir_rows[0].g = '{m1, m1, m1, p1, '0, '0, '0, p1, '0, '0, '0, p1};
    // all vertices equal
    dir_rows[1].typed = 1'b1;
    dir_rows[1].degen = 1'b1;
    for (int i = 0; i < 12; i++) dir_rows[2].tet.c[i] = coord_t'(32'h7FFFFFFF);
    dir_rows[2].typed = 1'b1;
    dir_rows[2].degen = 1'b1;
    for (int i = 0; i < 12; i++) dir_rows[3].tet.c[i] = coord_t'(32'h80000000);
    dir_rows[3].typed = 1'b1;
    dir_rows[3].degen = 1'b1;
    // tiny element saturates
    dir_rows[4].tet = unit_tet(coord_t'(1), '0);
    dir_rows[4].typed = 1'b1;
    dir_rows[4].g = '{grad_t'(32'h80000000), grad_t'(32'h80000000), grad_t'(32'h80000000),
                      grad_t'(32'h7FFFFFFF), '0, '0, '0, grad_t'(32'h7FFFFFFF), '0,
                      '0, '0, grad_t'(32'h7FFFFFFF)};
    // extreme spans, negative orientation, offsets
    dir_rows[5].tet = unit_tet(coord_t'(32'h7FFFFFFF), '0);
    dir_rows[6].tet = unit_tet(coord_t'(32'h7FFFFFFF), coord_t'(32'h80000000));
    dir_rows[7].tet = unit_tet(-one, '0);
    dir_rows[8].tet = unit_tet(coord_t'(3), coord_t'(32'h7FFFFFF0));
    dir_rows[9].tet = unit_tet(coord_t'(32'h80000000), coord_t'(32'h7FFFFFFF));
    // collinear
    dir_rows[10].tet = unit_tet(one, '0);
    dir_rows[10].tet.c[9] = one + one;
    dir_rows[10].tet.c[10] = '0;
    dir_rows[10].tet.c[11] = '0;
    dir_rows[10].tet.c[7] = '0;
    dir_rows[10].tet.c[6] = coord_t'(3 << FB);
    for (int r = 11; r < NDIR; r++)
      for (int i = 0; i < 12; i++)
        dir_rows[r].tet.c[i] = (((r + i) & 1) != 0) ? coord_t'($urandom)
                               : ~coord_t'($urandom);
    dir_rows[11].tet.c[0] = coord_t'(32'hFFFFFFFF);
    dir_rows[12].tet.c[0] = coord_t'(32'h00000000);
  endtask

  task automatic send_tet(tet_t t);
    @(negedge clk);
    in_valid <= 1'b1;
    for (int i = 0; i < 12; i++) vin[i] <= t.c[i];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 600) : 0;
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic queue_expected(tet_t t);
    shape_grad_t r[4];
    tet_gradients(t, r);
    for (int v = 0; v < 4; v++) pending_grads.push_back(r[v]);
  endtask

  // queue predictions at acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      tet_t t;
      for (int i = 0; i < 12; i++) t.c[i] = vin[i];
      queue_expected(t);
    end
  end

  task automatic check_field(string name, logic [GW-1:0] exp_v, logic [GW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid && out_ready) begin
      if (pending_grads.size() == 0) begin
        $error("unexpected result item, node_index %0d", node_index);
        errors++;
      end else begin
        shape_grad_t e;
        e = pending_grads.pop_front();
        check_field("node_index", GW'(e.node), GW'(node_index));
        check_field("grad_x", e.gx, grad_x);
        check_field("grad_y", e.gy, grad_y);
        check_field("grad_z", e.gz, grad_z);
        check_field("degenerate", GW'(e.degen), GW'(degenerate));
        check_field("last", GW'(e.last), GW'(last));
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stall pattern: randomly chosen phases of free flow, light stalls and heavy stalls
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) phase = $urandom_range(0, 2);
      case (phase)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // typed-in expectations for directed rows
  task automatic check_dir_row(int r);
    shape_grad_t p[4];
    tet_gradients(dir_rows[r].tet, p);
    for (int v = 0; v < 4; v++) begin
      if (p[v].degen !== dir_rows[r].degen || p[v].gx !== dir_rows[r].g[v * 3]
          || p[v].gy !== dir_rows[r].g[v * 3 + 1] || p[v].gz !== dir_rows[r].g[v * 3 + 2]) begin
        $error("row %0d node %0d: table and predictor disagree", r, v);
        errors++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 12; i++) vin[i] = '0;
    build_dir_rows();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int r = 0; r < NDIR; r++) begin
      if (dir_rows[r].typed) check_dir_row(r);
      send_tet(dir_rows[r].tet);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_grads.size() == 0);
    for (int n = 0; n < NRND; n++) begin
      if (n == NRND / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_grads.size() == 0);
      end
      send_tet(rand_tet());
      sender_gap();
    end
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_grads.size() == 0);
    repeat (1000) @(posedge clk);
    if (errors == 0 && pending_grads.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
